// File: rtl/mhpq_pkg.sv
package mhpq_pkg;

    localparam int DEPTH    = 256;
    localparam int ID_WIDTH = 16;
    localparam int COST_W   = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = ADDR_W + 1;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_UPDATE = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0] id;
        logic [COST_W-1:0]   cost;
    } entry_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0] node_id;
        status_t             status;
        logic [CNT_W-1:0]    count;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_LAST,
        S_DEL_CAP,
        S_DEL_LEFT,
        S_DEL_RIGHT,
        S_DEL_CMP,
        S_UPD_RD,
        S_UPD_CMP,
        S_SRT_RD,
        S_SRT_CUR,
        S_SRT_CMP,
        S_SRT_PUT,
        S_DONE
    } state_t;

    // heap position (1-based) to memory address
    function automatic logic [ADDR_W-1:0] pos2addr(input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] a;
        a = pos - CNT_W'(1);
        return a[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/min_heap_priority_queue_top.sv
// Binary min-heap priority queue of (node id, cost) entries, costs unsigned
// Q24.8 compared as plain integers. func 0 inserts, 1 removes the minimum and
// returns its id, 2 sets the cost of the first entry with a matching id and
// re-sorts the live entries stably by cost, 3 does nothing. Every input
// transaction yields exactly one result transaction with status, removed id
// (zero unless a delete succeeded) and the live count afterwards. One
// operation is in flight at a time. The entries sit in a single memory with
// one read port, one write port and a registered read, so each level of the
// heap walk takes a read state and a compare state for insert, and a left
// read, a right read and a compare state for delete. A full insert, an empty
// delete and func 3 go straight to the result state. Update searches the
// entries in order for the id, then insertion-sorts the live entries,
// shifting each larger entry one position on to make room for the moved one.
// A finished result waits in the output register while the next transaction
// is taken; while that register is still full, the walk holds in its last
// state until the result can move in.
module min_heap_priority_queue_top
    import mhpq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [ID_WIDTH-1:0] node_id,
    input  logic [COST_W-1:0]   cost,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ID_WIDTH-1:0] out_node_id,
    output logic [1:0]          status,
    output logic [CNT_W-1:0]    entry_count
);

    logic    busy;
    logic    done;
    logic    res_take;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    // output slot is free when empty or being drained this cycle
    assign res_take = !out_valid_reg || !out_stall;
    assign in_stall = busy;

    mhpq_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid && !busy),
        .func     (func),
        .node_id  (node_id),
        .cost     (cost),
        .res_take (res_take),
        .busy     (busy),
        .done     (done),
        .res      (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_node_id = out_reg.node_id;
    assign status      = out_reg.status;
    assign entry_count = out_reg.count;

endmodule

// File: rtl/mhpq_core.sv
module mhpq_core
    import mhpq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          func,
    input  logic [ID_WIDTH-1:0] node_id,
    input  logic [COST_W-1:0]   cost,
    input  logic                res_take,
    output logic                busy,
    output logic                done,
    output result_t             res
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    entry_t            wr_data;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    entry_t              mov_reg, mov_next;
    entry_t              left_reg, left_next;
    logic                has_r_reg, has_r_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [COST_W-1:0]   cost_reg, cost_next;
    logic [ID_WIDTH-1:0] taken_reg, taken_next;
    status_t             stat_reg, stat_next;

    logic [CNT_W:0]   left_pos;
    logic [CNT_W-1:0] left_trunc;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] j_dec;
    logic             take_left;
    entry_t           kid_ent;
    logic [CNT_W-1:0] kid_pos;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        j_reg     <= j_next;
        mov_reg   <= mov_next;
        left_reg  <= left_next;
        has_r_reg <= has_r_next;
        id_reg    <= id_next;
        cost_reg  <= cost_next;
        taken_reg <= taken_next;
        stat_reg  <= stat_next;
    end

    assign left_pos   = {pos_reg, 1'b0};
    assign left_trunc = left_pos[CNT_W-1:0];
    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign j_dec      = j_reg - CNT_W'(1);
    // right child wins ties
    assign take_left  = !has_r_reg || (left_reg.cost < rd_data_reg.cost);
    assign kid_ent    = take_left ? left_reg : rd_data_reg;
    assign kid_pos    = take_left ? left_trunc : left_trunc + CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        j_next     = j_reg;
        mov_next   = mov_reg;
        left_next  = left_reg;
        has_r_next = has_r_reg;
        id_next    = id_reg;
        cost_next  = cost_reg;
        taken_next = taken_reg;
        stat_next  = stat_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = mov_reg;
        done       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next    = node_id;
                    cost_next  = cost;
                    taken_next = '0;
                    stat_next  = STAT_OK;
                    mov_next   = '{id: node_id, cost: cost};
                    unique case (func_t'(func))
                        FN_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                stat_next  = STAT_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                pos_next   = cnt_reg + CNT_W'(1);
                                state_next = S_INS_RD;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = pos2addr(CNT_W'(1));
                                state_next = S_DEL_LAST;
                            end
                        end
                        FN_UPDATE:
                        begin
                            pos_next   = CNT_W'(1);
                            state_next = S_UPD_RD;
                        end
                        FN_NONE:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // sift up: one parent compare per level, in a read state and a compare state
            S_INS_RD:
            begin
                if (pos_reg == CNT_W'(1))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos2addr(pos_reg);
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos2addr(pos_reg >> 1);
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = pos2addr(pos_reg);
                if (mov_reg.cost < rd_data_reg.cost)
                begin
                    wr_data    = rd_data_reg;
                    pos_next   = pos_reg >> 1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DEL_LAST:
            begin
                taken_next = rd_data_reg.id;
                rd_en      = 1'b1;
                rd_addr    = pos2addr(cnt_reg);
                state_next = S_DEL_CAP;
            end

            S_DEL_CAP:
            begin
                mov_next   = rd_data_reg;
                cnt_next   = cnt_dec;
                pos_next   = CNT_W'(1);
                state_next = (cnt_dec == '0) ? S_DONE : S_DEL_LEFT;
            end

            S_DEL_LEFT:
            begin
                if (left_pos > {1'b0, cnt_reg})
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos2addr(pos_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos2addr(left_trunc);
                    state_next = S_DEL_RIGHT;
                end
            end

            S_DEL_RIGHT:
            begin
                left_next  = rd_data_reg;
                has_r_next = (left_trunc != cnt_reg);
                rd_en      = (left_trunc != cnt_reg);
                rd_addr    = pos2addr(left_trunc + CNT_W'(1));
                state_next = S_DEL_CMP;
            end

            S_DEL_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = pos2addr(pos_reg);
                if (mov_reg.cost < kid_ent.cost)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wr_data    = kid_ent;
                    pos_next   = kid_pos;
                    state_next = S_DEL_LEFT;
                end
            end

            // linear search for the first matching id
            S_UPD_RD:
            begin
                if (pos_reg > cnt_reg)
                begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos2addr(pos_reg);
                    state_next = S_UPD_CMP;
                end
            end

            S_UPD_CMP:
            begin
                if (rd_data_reg.id == id_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos2addr(pos_reg);
                    wr_data    = '{id: rd_data_reg.id, cost: cost_reg};
                    pos_next   = CNT_W'(2);
                    state_next = S_SRT_RD;
                end
                else
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_UPD_RD;
                end
            end

            // stable insertion sort over the live entries
            S_SRT_RD:
            begin
                if (pos_reg > cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos2addr(pos_reg);
                    state_next = S_SRT_CUR;
                end
            end

            S_SRT_CUR:
            begin
                mov_next   = rd_data_reg;
                j_next     = pos_reg;
                rd_en      = 1'b1;
                rd_addr    = pos2addr(pos_reg - CNT_W'(1));
                state_next = S_SRT_CMP;
            end

            S_SRT_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = pos2addr(j_reg);
                if (rd_data_reg.cost > mov_reg.cost)
                begin
                    wr_data = rd_data_reg;
                    j_next  = j_dec;
                    if (j_dec == CNT_W'(1))
                    begin
                        state_next = S_SRT_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos2addr(j_dec - CNT_W'(1));
                    end
                end
                else
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_SRT_RD;
                end
            end

            S_SRT_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos2addr(j_reg);
                pos_next   = pos_reg + CNT_W'(1);
                state_next = S_SRT_RD;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign res.node_id = taken_reg;
    assign res.status  = stat_reg;
    assign res.count   = cnt_reg;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("live count above depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of one entry in one cycle");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            ((cnt_reg == $past(cnt_reg) + CNT_W'(1)) ||
             (cnt_reg == $past(cnt_reg) - CNT_W'(1))))
        else $error("live count moved by more than one");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == S_IDLE))
        else $error("no return to idle after result");
`endif

endmodule
